@@ rtl/rdat_pkg.sv @@
// shared types and constants for the ack tracker
package rdat_pkg;

	localparam int PEND_DEPTH   = 16;
	localparam int PIDX_W       = $clog2(PEND_DEPTH);
	localparam int RECENT_DEPTH = 32;
	localparam int RIDX_W       = $clog2(RECENT_DEPTH);
	localparam int FILL_W       = $clog2(RECENT_DEPTH + 1);
	localparam int ID_W         = 32;
	localparam int DIG_W        = 64;
	localparam int TIME_W       = 32;
	localparam int RS_W         = 8;
	localparam int TICKS_W      = 16;
	localparam int CAP_W        = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_W        = 16;
	localparam int OP_W         = 3;
	localparam int KIND_W       = 3;
	localparam int IN_DATA_W    = 96;
	localparam int OUT_DATA_W   = 104;

	localparam logic [CFG_IDX_W-1:0] CFG_RESEND_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESEND_CAP   = 2'd2;

	localparam logic [TICKS_W-1:0] RESEND_TICKS_RST = 16'd200;
	localparam logic [TICKS_W-1:0] DEDUP_TICKS_RST  = 16'd2000;
	localparam logic [CAP_W-1:0]   RESEND_CAP_RST   = 8'd40;
	localparam logic [RS_W-1:0]    RS_MAX           = 8'd255;

	typedef enum logic [OP_W-1:0] {
		OP_SEND  = 3'd0,
		OP_RECV  = 3'd1,
		OP_ACK   = 3'd2,
		OP_TICK  = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		K_TRACKED   = 3'd0,
		K_FULL      = 3'd1,
		K_ACK_OUT   = 3'd2,
		K_MATCHED   = 3'd3,
		K_UNMATCHED = 3'd4,
		K_RESEND    = 3'd5,
		K_CLEARED   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_RX,
		ST_ACK,
		ST_TMASK,
		ST_TEMIT,
		ST_AGE,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [DIG_W-1:0] dig;
	} cmd_t;

endpackage

@@ rtl/rdat_front.sv @@
// input stage: accepts transactions, drops unused op codes, registers the command
module rdat_front import rdat_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // msg_id[31:0], digest[95:32]
	input  logic [OP_W-1:0]      s_tuser,  // op[2:0]
	output logic                 cmd_valid,
	output cmd_t                 cmd,
	input  logic                 cmd_ready
);

	logic vld_s1;
	cmd_t cmd_s1;
	logic op_ok;

	always_comb begin
		unique case (s_tuser)
			OP_SEND, OP_RECV, OP_ACK, OP_TICK, OP_CLEAR: op_ok = 1'b1;
			default: op_ok = 1'b0;
		endcase
	end

	assign s_tready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && op_ok) begin
			cmd_s1.op  <= op_t'(s_tuser);
			cmd_s1.id  <= s_tdata[ID_W-1:0];
			cmd_s1.dig <= s_tdata[ID_W+DIG_W-1:ID_W];
		end
	end

endmodule

@@ rtl/rdat_cmd_fifo.sv @@
// two-entry command queue between the input stage and the engine
module rdat_cmd_fifo import rdat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_cmd,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_cmd
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd   = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_cmd;
	end

endmodule

@@ rtl/rdat_engine.sv @@
// back end: pending table, recent-id list, tick scans and the result register
module rdat_engine import rdat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  cmd_t                  q_cmd,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_id[31:0], out_digest[95:32], deliver[96], timed_out[97]
	output logic [KIND_W-1:0]     m_tuser,  // kind[2:0]
	output logic                  m_tlast
);

	// configuration
	logic [TICKS_W-1:0] resend_q;
	logic [TICKS_W-1:0] dedup_q;
	logic [CAP_W-1:0]   cap_q;

	// pending table
	logic [PEND_DEPTH-1:0] pend_vld_q;
	logic [ID_W-1:0]       pend_id_q   [PEND_DEPTH];
	logic [DIG_W-1:0]      pend_dig_q  [PEND_DEPTH];
	logic [TIME_W-1:0]     pend_time_q [PEND_DEPTH];
	logic [RS_W-1:0]       pend_rs_q   [PEND_DEPTH];

	// recent-id list, oldest at index 0
	logic [ID_W-1:0]   rec_id_q   [RECENT_DEPTH];
	logic [TIME_W-1:0] rec_time_q [RECENT_DEPTH];
	logic [FILL_W-1:0] fill_q;

	logic [TIME_W-1:0]     now_q;
	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [FILL_W-1:0]     idx_q;
	logic [PEND_DEPTH-1:0] due_q;

	// result register
	logic              m_valid_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   oid_q;
	logic [DIG_W-1:0]  odig_q;
	logic              dlv_q;
	logic              tmo_q;
	logic              last_q;

	// control
	logic                  can_emit;
	logic                  emit;
	kind_t                 e_kind;
	logic [ID_W-1:0]       e_id;
	logic [DIG_W-1:0]      e_dig;
	logic                  e_dlv;
	logic                  e_tmo;
	logic                  e_last;
	logic                  cmd_load;
	logic                  idx_inc;
	logic                  now_inc;
	logic                  due_load;
	logic                  pend_wr;
	logic                  pend_clr;
	logic                  pend_upd;
	logic                  pend_clr_all;
	logic                  rec_wr;
	logic [RIDX_W-1:0]     rec_wr_idx;
	logic                  rec_shift;
	logic [RIDX_W-1:0]     rec_from;
	logic                  fill_inc;
	logic                  fill_dec;
	logic                  fill_clr;
	logic [PEND_DEPTH-1:0] due_d;
	logic                  free_any;
	logic [PIDX_W-1:0]     free_idx;
	logic [PIDX_W-1:0]     sel_idx;
	logic [PEND_DEPTH-1:0] sel_oh;
	logic [PIDX_W-1:0]     pa;
	logic [FILL_W-1:0]     fill_m1;
	logic                  in_range;
	logic                  hit_r;
	logic                  hit_a;
	logic [TIME_W-1:0]     age0;

	assign can_emit = !m_valid_q || m_tready;
	assign fill_m1  = fill_q - FILL_W'(1);
	assign pa       = (state_q == ST_TEMIT) ? sel_idx : idx_q[PIDX_W-1:0];
	assign in_range = idx_q < fill_q;
	assign hit_r    = in_range && (rec_id_q[idx_q[RIDX_W-1:0]] == cmd_q.id);
	assign hit_a    = pend_vld_q[pa] && (pend_id_q[pa] == cmd_q.id)
	                  && (pend_dig_q[pa] == cmd_q.dig);
	assign age0     = now_q - rec_time_q[0];

	// lowest free entry, lowest due entry, and the due mask
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		sel_idx  = '0;
		for (int k = PEND_DEPTH - 1; k >= 0; k--) begin
			if (!pend_vld_q[k]) begin
				free_any = 1'b1;
				free_idx = PIDX_W'(k);
			end
			if (due_q[k]) sel_idx = PIDX_W'(k);
		end
		sel_oh = '0;
		sel_oh[sel_idx] = 1'b1;
		for (int k = 0; k < PEND_DEPTH; k++) begin
			due_d[k] = pend_vld_q[k]
			           && ((now_q - pend_time_q[k]) > {{(TIME_W-TICKS_W){1'b0}}, resend_q});
		end
	end

	always_comb begin
		state_d      = state_q;
		q_ready      = 1'b0;
		cmd_load     = 1'b0;
		idx_inc      = 1'b0;
		now_inc      = 1'b0;
		due_load     = 1'b0;
		emit         = 1'b0;
		e_kind       = K_TRACKED;
		e_id         = cmd_q.id;
		e_dig        = '0;
		e_dlv        = 1'b0;
		e_tmo        = 1'b0;
		e_last       = 1'b1;
		pend_wr      = 1'b0;
		pend_clr     = 1'b0;
		pend_upd     = 1'b0;
		pend_clr_all = 1'b0;
		rec_wr       = 1'b0;
		rec_wr_idx   = fill_m1[RIDX_W-1:0];
		rec_shift    = 1'b0;
		rec_from     = '0;
		fill_inc     = 1'b0;
		fill_dec     = 1'b0;
		fill_clr     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					cmd_load = 1'b1;
					unique case (q_cmd.op)
						OP_SEND:  state_d = ST_SEND;
						OP_RECV:  state_d = ST_RX;
						OP_ACK:   state_d = ST_ACK;
						OP_TICK: begin
							now_inc = 1'b1;
							state_d = ST_TMASK;
						end
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEND: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_kind  = free_any ? K_TRACKED : K_FULL;
					pend_wr = free_any;
					state_d = ST_IDLE;
				end
			end
			ST_RX: begin
				if (!in_range || hit_r) begin
					if (can_emit) begin
						emit   = 1'b1;
						e_kind = K_ACK_OUT;
						e_dig  = cmd_q.dig;
						e_dlv  = !hit_r;
						rec_wr = 1'b1;
						if (hit_r) begin
							// move the refreshed id to the end
							rec_shift = 1'b1;
							rec_from  = idx_q[RIDX_W-1:0];
						end else if (fill_q == FILL_W'(RECENT_DEPTH)) begin
							// list full: drop the oldest first
							rec_shift = 1'b1;
						end else begin
							rec_wr_idx = fill_q[RIDX_W-1:0];
							fill_inc   = 1'b1;
						end
						state_d = ST_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_ACK: begin
				if (hit_a) begin
					if (can_emit) begin
						emit     = 1'b1;
						e_kind   = K_MATCHED;
						pend_clr = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (idx_q[PIDX_W-1:0] == PIDX_W'(PEND_DEPTH - 1)) begin
					if (can_emit) begin
						emit    = 1'b1;
						e_kind  = K_UNMATCHED;
						state_d = ST_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_TMASK: begin
				due_load = 1'b1;
				state_d  = (due_d != '0) ? ST_TEMIT : ST_AGE;
			end
			ST_TEMIT: begin
				if (can_emit) begin
					emit     = 1'b1;
					e_kind   = K_RESEND;
					e_id     = pend_id_q[pa];
					e_tmo    = pend_rs_q[pa] > cap_q;
					e_last   = (due_q & ~sel_oh) == '0;
					pend_upd = 1'b1;
					if (e_last) state_d = ST_AGE;
				end
			end
			ST_AGE: begin
				if (fill_q != '0 && age0 > {{(TIME_W-TICKS_W){1'b0}}, dedup_q}) begin
					rec_shift = 1'b1;
					fill_dec  = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (can_emit) begin
					emit         = 1'b1;
					e_kind       = K_CLEARED;
					e_id         = '0;
					pend_clr_all = 1'b1;
					fill_clr     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			resend_q   <= RESEND_TICKS_RST;
			dedup_q    <= DEDUP_TICKS_RST;
			cap_q      <= RESEND_CAP_RST;
			pend_vld_q <= '0;
			fill_q     <= '0;
			now_q      <= '0;
			idx_q      <= '0;
			due_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_RESEND_TICKS: resend_q <= cfg_wdata;
					CFG_DEDUP_TICKS:  dedup_q  <= cfg_wdata;
					CFG_RESEND_CAP:   cap_q    <= cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (cmd_load) idx_q <= '0;
			else if (idx_inc) idx_q <= idx_q + FILL_W'(1);
			if (now_inc) now_q <= now_q + TIME_W'(1);
			if (due_load) due_q <= due_d;
			else if (pend_upd) due_q <= due_q & ~sel_oh;
			if (pend_clr_all) pend_vld_q <= '0;
			else if (pend_wr) pend_vld_q[free_idx] <= 1'b1;
			else if (pend_clr) pend_vld_q[pa] <= 1'b0;
			if (fill_clr) fill_q <= '0;
			else if (fill_inc) fill_q <= fill_q + FILL_W'(1);
			else if (fill_dec) fill_q <= fill_m1;
			if (emit) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) cmd_q <= q_cmd;
		if (pend_wr) begin
			pend_id_q[free_idx]   <= cmd_q.id;
			pend_dig_q[free_idx]  <= cmd_q.dig;
			pend_time_q[free_idx] <= now_q;
			pend_rs_q[free_idx]   <= '0;
		end
		if (pend_upd) begin
			pend_time_q[pa] <= now_q;
			if (pend_rs_q[pa] != RS_MAX) pend_rs_q[pa] <= pend_rs_q[pa] + RS_W'(1);
		end
		if (rec_shift) begin
			for (int j = 0; j < RECENT_DEPTH - 1; j++) begin
				if (RIDX_W'(j) >= rec_from) begin
					rec_id_q[j]   <= rec_id_q[j+1];
					rec_time_q[j] <= rec_time_q[j+1];
				end
			end
		end
		// write after the shift so that it wins on the same entry
		if (rec_wr) begin
			rec_id_q[rec_wr_idx]   <= cmd_q.id;
			rec_time_q[rec_wr_idx] <= now_q;
		end
		if (emit) begin
			kind_q <= e_kind;
			oid_q  <= e_id;
			odig_q <= e_dig;
			dlv_q  <= e_dlv;
			tmo_q  <= e_tmo;
			last_q <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_W-ID_W-DIG_W-2){1'b0}}, tmo_q, dlv_q, odig_q, oid_q};

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RECENT_DEPTH))
		else $error("recent fill beyond depth");
	a_emit_has_due: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEMIT |-> due_q != '0)
		else $error("resend state with nothing due");
	a_not_last_more: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !e_last) |=> state_q == ST_TEMIT)
		else $error("non-final result not followed by another resend");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_load |-> state_q == ST_IDLE)
		else $error("command taken while busy");
`endif

endmodule

@@ rtl/reliable_delivery_ack_tracker.sv @@
// Acknowledged-delivery tracker: a 16-entry retransmit table and a 32-entry
// duplicate filter. Commands enter through a registered input stage and a
// two-entry queue, then run one at a time in the engine, whose result register
// lets the next command start while a result waits. The engine's scans step one
// entry per cycle: a received message searches the recent ids, an acknowledge
// the pending table, and a tick marks the due entries, resends each one and
// drops aged ids. Results stall the engine while the output is held.
module reliable_delivery_ack_tracker import rdat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // msg_id[31:0], digest[95:32]
	input  logic [OP_W-1:0]       s_tuser,  // op[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_id[31:0], out_digest[95:32], deliver[96], timed_out[97]
	output logic [KIND_W-1:0]     m_tuser,  // kind[2:0]
	output logic                  m_tlast
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	rdat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready)
	);

	rdat_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	rdat_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ bench/reliable_delivery_ack_tracker_chk.sv @@
// result checker for the ack tracker: mirrors its tables and compares every output transaction
`timescale 1ns / 100ps
module reliable_delivery_ack_tracker_chk import rdat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [OP_W-1:0]       s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [KIND_W-1:0]     m_tuser,
	input  logic                  m_tlast,
	output int                    errors,
	output int                    outstanding
);
	typedef struct {
		kind_t            kind;
		logic [ID_W-1:0]  id;
		logic [DIG_W-1:0] dig;
		logic             dlv;
		logic             tmo;
		logic             lst;
	} verdict_t;

	verdict_t                expected_q[$];
	logic [TICKS_W-1:0]      resend_ticks;
	logic [TICKS_W-1:0]      dedup_ticks;
	logic [CAP_W-1:0]        resend_cap;
	logic                    p_valid[PEND_DEPTH];
	logic [ID_W-1:0]         p_id[PEND_DEPTH];
	logic [DIG_W-1:0]        p_dig[PEND_DEPTH];
	logic [TIME_W-1:0]       p_sent[PEND_DEPTH];
	logic [RS_W-1:0]         p_rs[PEND_DEPTH];
	logic [ID_W-1:0]         r_id[$];
	logic [TIME_W-1:0]       r_time[$];
	logic [TIME_W-1:0]       now;

	assign outstanding = expected_q.size();

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic push(input kind_t k, input logic [ID_W-1:0] id, input logic [DIG_W-1:0] d,
			input logic dl, input logic tm);
		verdict_t v;
		v.kind = k; v.id = id; v.dig = d; v.dlv = dl; v.tmo = tm; v.lst = 1'b0;
		expected_q = {expected_q, v};
	endtask

	// applies one accepted command to the mirrored tables
	task automatic track_command(input op_t op, input logic [ID_W-1:0] id,
			input logic [DIG_W-1:0] d);
		int n;
		int hit;
		n = 0;
		hit = -1;
		case (op)
			OP_SEND: begin
				for (int i = 0; i < PEND_DEPTH; i++)
					if (!p_valid[i] && hit < 0) hit = i;
				if (hit >= 0) begin
					p_valid[hit] = 1'b1; p_id[hit] = id; p_dig[hit] = d;
					p_sent[hit] = now; p_rs[hit] = '0;
					push(K_TRACKED, id, '0, 0, 0);
				end else begin
					push(K_FULL, id, '0, 0, 0);
				end
				n = 1;
			end
			OP_RECV: begin
				for (int i = 0; i < r_id.size(); i++)
					if (r_id[i] == id && hit < 0) hit = i;
				if (hit >= 0) begin
					r_id.delete(hit); r_time.delete(hit);
				end else if (r_id.size() >= RECENT_DEPTH) begin
					void'(r_id.pop_front()); void'(r_time.pop_front());
				end
				r_id = {r_id, id}; r_time = {r_time, now};
				push(K_ACK_OUT, id, d, hit < 0, 0);
				n = 1;
			end
			OP_ACK: begin
				for (int i = 0; i < PEND_DEPTH; i++)
					if (hit < 0 && p_valid[i] && p_id[i] == id && p_dig[i] == d) hit = i;
				if (hit >= 0) p_valid[hit] = 1'b0;
				push(hit >= 0 ? K_MATCHED : K_UNMATCHED, id, '0, 0, 0);
				n = 1;
			end
			OP_TICK: begin
				now++;
				for (int i = 0; i < PEND_DEPTH; i++)
					if (p_valid[i] && TIME_W'(now - p_sent[i]) > TIME_W'(resend_ticks)) begin
						push(K_RESEND, p_id[i], '0, 0, p_rs[i] > resend_cap);
						p_sent[i] = now;
						if (p_rs[i] != RS_MAX) p_rs[i]++;
						n++;
					end
				while (r_id.size() > 0 && TIME_W'(now - r_time[0]) > TIME_W'(dedup_ticks)) begin
					void'(r_id.pop_front()); void'(r_time.pop_front());
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < PEND_DEPTH; i++) p_valid[i] = 1'b0;
				r_id.delete(); r_time.delete();
				push(K_CLEARED, '0, '0, 0, 0);
				n = 1;
			end
			default: ;
		endcase
		if (n > 0) expected_q[$].lst = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			expected_q.delete();
			resend_ticks = RESEND_TICKS_RST;
			dedup_ticks = DEDUP_TICKS_RST;
			resend_cap = RESEND_CAP_RST;
			for (int i = 0; i < PEND_DEPTH; i++) p_valid[i] = 1'b0;
			r_id.delete(); r_time.delete();
			now = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RESEND_TICKS: resend_ticks = cfg_wdata;
					CFG_DEDUP_TICKS:  dedup_ticks = cfg_wdata;
					CFG_RESEND_CAP:   resend_cap = cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected result kind %0d id %h", m_tuser, m_tdata[31:0]));
				end else begin
					verdict_t v;
					v = expected_q.pop_front();
					if (m_tuser !== v.kind)
						report($sformatf("kind %0d, want %0d", m_tuser, v.kind));
					if (m_tdata[31:0] !== v.id)
						report($sformatf("out_id %h, want %h", m_tdata[31:0], v.id));
					if (m_tdata[95:32] !== v.dig)
						report($sformatf("out_digest %h, want %h", m_tdata[95:32], v.dig));
					if (m_tdata[96] !== v.dlv)
						report($sformatf("deliver %b, want %b", m_tdata[96], v.dlv));
					if (m_tdata[97] !== v.tmo)
						report($sformatf("timed_out %b, want %b", m_tdata[97], v.tmo));
					if (m_tlast !== v.lst)
						report($sformatf("tlast %b, want %b", m_tlast, v.lst));
				end
			end
			if (s_tvalid && s_tready)
				track_command(op_t'(s_tuser), s_tdata[31:0], s_tdata[95:32]);
		end
	end
endmodule

@@ bench/reliable_delivery_ack_tracker_tb.sv @@
// stimulus top for the ack tracker bench: drives commands and registers, gives the verdict
`timescale 1ns / 100ps
module reliable_delivery_ack_tracker_tb;
	import rdat_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	int                    errors;
	int                    outstanding;
	logic                  calm;
	logic [ID_W-1:0]       id_pool[8];
	logic [DIG_W-1:0]      dig_pool[8];

	reliable_delivery_ack_tracker dut (.*);
	reliable_delivery_ack_tracker_chk chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// receiver stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b1;
		end else begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// tvalid stays high after acceptance until the next command or drain drops it
	task automatic send_cmd(input op_t op, input logic [ID_W-1:0] id, input logic [DIG_W-1:0] d);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {d, id};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count);
		op_t              op;
		int               k;
		logic [ID_W-1:0]  id;
		logic [DIG_W-1:0] d;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 7);
			id = ($urandom_range(0, 3) == 0) ? $urandom : id_pool[k];
			d = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : dig_pool[k];
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:  op = OP_SEND;
				5, 6, 7, 8, 9:  op = OP_RECV;
				10, 11, 12, 13: op = OP_ACK;
				19:             op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_TICK;
				default:        op = OP_TICK;
			endcase
			send_cmd(op, id, d);
		end
	endtask

	initial begin
		#20_000_000;
		$display("FAIL reliable_delivery_ack_tracker");
		$finish;
	end

	initial begin
		calm = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		for (int i = 0; i < 8; i++) begin
			id_pool[i] = $urandom;
			dig_pool[i] = {$urandom, $urandom};
		end
		id_pool[0] = '0; dig_pool[0] = '0;
		id_pool[1] = '1; dig_pool[1] = '1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, fill the pending table past full, duplicates, acks, ticks, unused op codes, clear
		write_reg(CFG_RESEND_TICKS, 16'd1);
		write_reg(CFG_DEDUP_TICKS, 16'd1);
		write_reg(CFG_RESEND_CAP, 16'd0);
		send_cmd(OP_SEND, '0, '0);
		send_cmd(OP_SEND, '1, '1);
		for (int i = 0; i < 15; i++) send_cmd(OP_SEND, $urandom, {$urandom, $urandom});
		send_cmd(OP_RECV, '1, '1);
		send_cmd(OP_RECV, '1, '0);
		send_cmd(OP_ACK, '1, '0);
		send_cmd(OP_ACK, '1, '1);
		for (int i = 0; i < 4; i++) send_cmd(OP_TICK, '0, '0);
		send_cmd(op_t'(3'd5), '1, '1);
		send_cmd(op_t'(3'd7), '0, '0);
		send_cmd(OP_CLEAR, '0, '0);
		drain();

		// overflow the recent list
		write_reg(CFG_DEDUP_TICKS, 16'hFFFF);
		for (int i = 0; i < 40; i++) send_cmd(OP_RECV, i, {$urandom, $urandom});
		send_cmd(OP_RECV, 32'd39, '0);
		send_cmd(OP_RECV, 32'd0, '0);
		drain();

		write_reg(CFG_RESEND_TICKS, 16'd2);
		write_reg(CFG_DEDUP_TICKS, 16'd6);
		write_reg(CFG_RESEND_CAP, 16'd3);
		random_phase(120);
		drain();

		write_reg(CFG_RESEND_TICKS, 16'hFFFF);
		write_reg(CFG_DEDUP_TICKS, 16'd30);
		write_reg(CFG_RESEND_CAP, 16'd255);
		random_phase(80);
		drain();

		write_reg(CFG_RESEND_TICKS, 16'd1);
		write_reg(CFG_DEDUP_TICKS, 16'd3);
		write_reg(CFG_RESEND_CAP, 16'd1);
		random_phase(60);
		calm = 1'b1;
		random_phase(60);
		drain();

		if (errors == 0)
			$display("PASS reliable_delivery_ack_tracker");
		else
			$display("FAIL reliable_delivery_ack_tracker");
		$finish;
	end
endmodule
